FILE: src/cifl_pkg.sv
package cifl_pkg;

    typedef enum logic [2:0] {
        PH_IMAGE_HDR,
        PH_CHIP_HDR,
        PH_LOW_ONLY,
        PH_LOW_IL,
        PH_HIGH_IL
    } phase_t;

    // bank switch mode codes
    localparam logic [4:0] MODE_NONE = 5'd0;
    localparam logic [4:0] MODE_T32  = 5'd1;
    localparam logic [4:0] MODE_T19  = 5'd2;
    localparam logic [4:0] MODE_T7   = 5'd3;
    localparam logic [4:0] MODE_T43  = 5'd4;
    localparam logic [4:0] MODE_T57R = 5'd5;
    localparam logic [4:0] MODE_T57H = 5'd6;
    localparam logic [4:0] MODE_T3   = 5'd7;
    localparam logic [4:0] MODE_T1   = 5'd8;
    localparam logic [4:0] MODE_T9   = 5'd9;
    localparam logic [4:0] MODE_T15  = 5'd10;
    localparam logic [4:0] MODE_T60  = 5'd11;
    localparam logic [4:0] MODE_T18  = 5'd12;
    localparam logic [4:0] MODE_T5   = 5'd13;
    localparam logic [4:0] MODE_T21  = 5'd14;
    localparam logic [4:0] MODE_T10  = 5'd15;
    localparam logic [4:0] MODE_T4   = 5'd16;
    localparam logic [4:0] MODE_T17  = 5'd17;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_IMAGE = 2'd1;
    localparam logic [1:0] ST_BAD_CHIP  = 2'd2;
    localparam logic [1:0] ST_BAD_BANK  = 2'd3;

    localparam logic [15:0] TYPE_LOW_ONLY = 16'd36;
    localparam logic [15:0] ADDR_ROML     = 16'h8000;
    localparam logic [15:0] ADDR_ROMH_F   = 16'hf000;
    localparam logic [15:0] ADDR_ROMH_B   = 16'hb000;
    localparam logic [15:0] BANK_BYTES    = 16'd8192;

    typedef struct packed {
        logic [4:0] mode;
        logic [1:0] rom;
    } type_map_t;

    typedef struct packed {
        logic        write_enable;
        logic [19:0] flash_address;
        logic [7:0]  flash_data;
        logic [4:0]  cart_mode;
        logic [1:0]  rom_lines;
        logic [6:0]  bank_count;
        logic [1:0]  status;
        logic        end_of_image;
    } res_t;

    function automatic logic [7:0] image_sig(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0:    v = 8'h43;
            4'd1:    v = 8'h36;
            4'd2:    v = 8'h34;
            4'd3:    v = 8'h20;
            4'd4:    v = 8'h43;
            4'd5:    v = 8'h41;
            4'd6:    v = 8'h52;
            4'd7:    v = 8'h54;
            4'd8:    v = 8'h52;
            4'd9:    v = 8'h49;
            4'd10:   v = 8'h44;
            4'd11:   v = 8'h47;
            4'd12:   v = 8'h45;
            default: v = 8'h20;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] chip_sig(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h43;
            2'd1:    v = 8'h48;
            2'd2:    v = 8'h49;
            default: v = 8'h50;
        endcase
        return v;
    endfunction

    function automatic type_map_t map_type(input logic [15:0] code, input logic [7:0] rsv0);
        type_map_t m;
        m.rom = 2'd1;
        case (code)
            16'd32:  begin m.mode = MODE_T32; m.rom = 2'd3; end
            16'd19:  m.mode = MODE_T19;
            16'd7:   m.mode = MODE_T7;
            16'd43:  m.mode = MODE_T43;
            16'd57:  m.mode = (rsv0 == 8'd0) ? MODE_T57R : MODE_T57H;
            16'd3:   begin m.mode = MODE_T3; m.rom = 2'd3; end
            16'd1:   m.mode = MODE_T1;
            16'd9:   m.mode = MODE_T9;
            16'd15:  m.mode = MODE_T15;
            16'd60:  m.mode = MODE_T60;
            16'd18:  m.mode = MODE_T18;
            16'd5:   m.mode = MODE_T5;
            16'd21:  begin m.mode = MODE_T21; m.rom = 2'd3; end
            16'd10:  m.mode = MODE_T10;
            16'd4:   m.mode = MODE_T4;
            16'd17:  m.mode = MODE_T17;
            default: begin m.mode = MODE_NONE; m.rom = 2'd0; end
        endcase
        return m;
    endfunction

    function automatic logic low_only(input logic [4:0] mode, input logic [15:0] code);
        logic r;
        case (mode)
            MODE_T19, MODE_T15, MODE_T7, MODE_T43,
            MODE_T5, MODE_T60, MODE_T57H, MODE_T57R: r = 1'b1;
            default: r = (code == TYPE_LOW_ONLY);
        endcase
        return r;
    endfunction

endpackage

FILE: src/cartridge_image_flash_loader.sv
// an input byte is held in the input register stage, then its parse result in the result register stage
// throughput: one image byte per cycle while m_axis_tready holds, set by the single registered parse step
// reset: rst_n clears parse state, raw_order and the valid flags of both stream stages at once
// an input transaction with tlast set ends the image; the next byte starts a new one
module cartridge_image_flash_loader #(
    parameter int MAX_BANKS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] file_byte
    input  logic        s_axis_tlast,   // last_byte
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] write_enable, [20:1] flash_address, [28:21] flash_data,
    // [33:29] cart_mode, [35:34] rom_lines, [42:36] bank_count,
    // [44:43] status, [47:45] zero
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast,   // end_of_image
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data        // raw_order
);
    import cifl_pkg::*;

    logic       raw_order_reg, raw_order_next;
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg, in_byte_next;
    logic       in_last_reg, in_last_next;
    logic       res_valid_reg, res_valid_next;
    res_t       res_reg, res_next;

    logic       out_free;
    logic       step;
    logic       s_take;
    logic       m_take;
    res_t       core_res;

    // result slot can be refilled when empty or being drained this cycle
    assign out_free      = !res_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign s_take        = s_axis_tvalid && s_axis_tready;
    assign m_take        = res_valid_reg && m_axis_tready;
    assign cfg_ready     = 1'b1;

    cifl_core #(
        .MAX_BANKS (MAX_BANKS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .file_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .raw_order (raw_order_reg),
        .result    (core_res)
    );

    always_comb
    begin
        raw_order_next = (cfg_valid && cfg_ready) ? cfg_data[0] : raw_order_reg;

        // input register stage
        in_byte_next  = s_take ? s_axis_tdata : in_byte_reg;
        in_last_next  = s_take ? s_axis_tlast : in_last_reg;
        in_valid_next = s_take ? 1'b1 : (step ? 1'b0 : in_valid_reg);

        // result register stage
        res_next       = step ? core_res : res_reg;
        res_valid_next = step ? 1'b1 : (m_take ? 1'b0 : res_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_order_reg <= 1'b0;
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            raw_order_reg <= raw_order_next;
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
        in_last_reg <= in_last_next;
        res_reg     <= res_next;
    end

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tlast  = res_reg.end_of_image;
    assign m_axis_tdata  = {3'd0, res_reg.status, res_reg.bank_count, res_reg.rom_lines,
                            res_reg.cart_mode, res_reg.flash_data, res_reg.flash_address,
                            res_reg.write_enable};

    // a flash write is only ever issued while the image is still clean
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.write_enable |-> res_reg.status == ST_OK)
        else $error("flash write issued with error status");

    // no write means zeroed address and data
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.write_enable
            |-> res_reg.flash_address == 20'd0 && res_reg.flash_data == 8'd0)
        else $error("idle result carries address or data");

    // an empty result slot never blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty result slot");

    // a parsed byte always lands in the result slot on the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> res_valid_reg)
        else $error("parsed byte lost");

endmodule

FILE: src/cifl_core.sv
module cifl_core #(
    parameter int MAX_BANKS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  logic [7:0]     file_byte,
    input  logic           last_byte,
    input  logic           raw_order,
    output cifl_pkg::res_t result
);
    import cifl_pkg::*;

    localparam int BANK_W = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
    localparam logic [15:0] BANK_LIMIT = 16'(MAX_BANKS);

    phase_t             phase_reg, phase_next;
    logic [12:0]        pos_reg, pos_next;
    logic [15:0]        type_reg, type_next;
    logic [4:0]         mode_reg, mode_next;
    logic [1:0]         rom_reg, rom_next;
    logic [15:0]        bank_reg, bank_next;
    logic [15:0]        load_reg, load_next;
    logic [15:0]        len_reg, len_next;
    logic [13:0]        rem_reg, rem_next;
    logic               hi_reg, hi_next;
    logic [BANK_W-1:0]  top_bank_reg, top_bank_next;
    logic [1:0]         err_reg, err_next;

    logic [5:0]   hdr_pos;
    logic [3:0]   chip_pos;
    logic [15:0]  len_hi;
    logic [13:0]  rem_dec;
    logic [12:0]  idx;
    logic [12:0]  ofs;
    logic         bank_ok;
    logic         we;
    logic [19:0]  addr;
    logic [31:0]  bank_sum;
    type_map_t    tmap;

    assign hdr_pos  = pos_reg[5:0];
    assign chip_pos = pos_reg[3:0];
    assign bank_ok  = bank_reg < BANK_LIMIT;
    assign rem_dec  = (rem_reg == 14'd0) ? 14'd0 : rem_reg - 14'd1;
    assign len_hi   = len_reg - BANK_BYTES;
    assign idx      = pos_reg + {hi_reg, 12'd0};
    assign ofs      = raw_order ? idx : {idx[7:0], idx[12:8]};
    assign tmap     = map_type(type_reg, file_byte);

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        type_next     = type_reg;
        mode_next     = mode_reg;
        rom_next      = rom_reg;
        bank_next     = bank_reg;
        load_next     = load_reg;
        len_next      = len_reg;
        rem_next      = rem_reg;
        hi_next       = hi_reg;
        top_bank_next = top_bank_reg;
        err_next      = err_reg;
        case (phase_reg)
            PH_IMAGE_HDR:
            begin
                if (hdr_pos < 6'd16 && file_byte != image_sig(hdr_pos[3:0])
                    && err_reg == ST_OK)
                    err_next = ST_BAD_IMAGE;
                if (hdr_pos == 6'd22 || hdr_pos == 6'd23)
                    type_next = {type_reg[7:0], file_byte};
                if (hdr_pos == 6'd26)
                begin
                    mode_next = tmap.mode;
                    rom_next  = tmap.rom;
                end
                if (hdr_pos == 6'd63)
                begin
                    pos_next   = 13'd0;
                    phase_next = PH_CHIP_HDR;
                end
                else
                    pos_next = 13'(hdr_pos) + 13'd1;
            end
            PH_CHIP_HDR:
            begin
                if (chip_pos < 4'd4 && file_byte != chip_sig(chip_pos[1:0])
                    && err_reg == ST_OK)
                    err_next = ST_BAD_CHIP;
                if (chip_pos == 4'd10 || chip_pos == 4'd11)
                    bank_next = {bank_reg[7:0], file_byte};
                if (chip_pos == 4'd12 || chip_pos == 4'd13)
                    load_next = {load_reg[7:0], file_byte};
                if (chip_pos == 4'd14 || chip_pos == 4'd15)
                    len_next = {len_reg[7:0], file_byte};
                if (chip_pos == 4'd11 && bank_next >= BANK_LIMIT && err_reg == ST_OK)
                    err_next = ST_BAD_BANK;
                pos_next = 13'(chip_pos) + 13'd1;
                if (chip_pos == 4'd15)
                begin
                    // start of chip data
                    pos_next = 13'd0;
                    hi_next  = 1'b0;
                    if (bank_ok && bank_reg[BANK_W-1:0] > top_bank_reg)
                        top_bank_next = bank_reg[BANK_W-1:0];
                    if (low_only(mode_reg, type_reg))
                    begin
                        rom_next   = 2'd1;
                        rem_next   = (len_next > BANK_BYTES) ? 14'd8192 : len_next[13:0];
                        phase_next = PH_LOW_ONLY;
                    end
                    else if (load_reg == ADDR_ROML)
                    begin
                        rom_next   = rom_reg | 2'd1;
                        rem_next   = (len_next > BANK_BYTES) ? 14'd8192 : len_next[13:0];
                        phase_next = PH_LOW_IL;
                    end
                    else
                    begin
                        hi_next    = (load_reg == ADDR_ROMH_F || load_reg == ADDR_ROMH_B);
                        rom_next   = rom_reg | 2'd2;
                        rem_next   = hi_next ? 14'd4096 : 14'd8192;
                        phase_next = PH_HIGH_IL;
                    end
                    if (rem_next == 14'd0)
                        phase_next = PH_CHIP_HDR;
                end
            end
            PH_LOW_ONLY, PH_LOW_IL, PH_HIGH_IL:
            begin
                pos_next = pos_reg + 13'd1;
                rem_next = rem_dec;
                if (rem_dec == 14'd0)
                begin
                    pos_next = 13'd0;
                    if (phase_reg == PH_LOW_IL && len_reg > BANK_BYTES)
                    begin
                        rom_next   = rom_reg | 2'd2;
                        hi_next    = 1'b0;
                        rem_next   = (len_hi > BANK_BYTES) ? 14'd8192 : len_hi[13:0];
                        phase_next = PH_HIGH_IL;
                    end
                    else
                        phase_next = PH_CHIP_HDR;
                end
            end
            default:
                phase_next = PH_IMAGE_HDR;
        endcase
    end

    // write outputs
    always_comb
    begin
        we   = 1'b0;
        addr = 20'd0;
        case (phase_reg)
            PH_LOW_ONLY:
            begin
                we   = (err_reg == ST_OK) && bank_ok;
                addr = {bank_reg[6:0], ofs};
            end
            PH_LOW_IL:
            begin
                we   = (err_reg == ST_OK) && bank_ok;
                addr = {bank_reg[5:0], ofs, 1'b0};
            end
            PH_HIGH_IL:
            begin
                we   = (err_reg == ST_OK) && bank_ok;
                addr = {bank_reg[5:0], ofs, 1'b1};
            end
            default:
            begin
                we   = 1'b0;
                addr = 20'd0;
            end
        endcase
    end

    assign bank_sum = 32'(top_bank_next) + 32'd1;

    always_comb
    begin
        result.write_enable  = we;
        result.flash_address = we ? addr : 20'd0;
        result.flash_data    = we ? file_byte : 8'd0;
        result.cart_mode     = mode_next;
        result.rom_lines     = rom_next;
        result.bank_count    = bank_sum[6:0];
        result.status        = err_next;
        result.end_of_image  = last_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IMAGE_HDR;
            pos_reg      <= '0;
            type_reg     <= '0;
            mode_reg     <= MODE_NONE;
            rom_reg      <= '0;
            bank_reg     <= '0;
            load_reg     <= '0;
            len_reg      <= '0;
            rem_reg      <= '0;
            hi_reg       <= 1'b0;
            top_bank_reg <= '0;
            err_reg      <= ST_OK;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                // image ends: back to a fresh parse
                phase_reg    <= PH_IMAGE_HDR;
                pos_reg      <= '0;
                type_reg     <= '0;
                mode_reg     <= MODE_NONE;
                rom_reg      <= '0;
                bank_reg     <= '0;
                load_reg     <= '0;
                len_reg      <= '0;
                rem_reg      <= '0;
                hi_reg       <= 1'b0;
                top_bank_reg <= '0;
                err_reg      <= ST_OK;
            end
            else
            begin
                phase_reg    <= phase_next;
                pos_reg      <= pos_next;
                type_reg     <= type_next;
                mode_reg     <= mode_next;
                rom_reg      <= rom_next;
                bank_reg     <= bank_next;
                load_reg     <= load_next;
                len_reg      <= len_next;
                rem_reg      <= rem_next;
                hi_reg       <= hi_next;
                top_bank_reg <= top_bank_next;
                err_reg      <= err_next;
            end
        end
    end

endmodule

FILE: dv/loader_check_pkg.sv
package loader_check_pkg;

    import cifl_pkg::*;

    localparam int BANK_LIMIT = 64;

    // header signatures, byte 0 in the lowest bits
    localparam logic [127:0] IMAGE_MAGIC = 128'h20202045_47444952_54524143_20343643;
    localparam logic [31:0]  CHIP_MAGIC  = 32'h50494843;

    class flash_write_tracker;

        logic        raw_order;
        phase_t      state;
        logic [13:0] pos;
        logic [15:0] type_code;
        logic [4:0]  mode;
        logic [1:0]  rom;
        logic [15:0] bank;
        logic [15:0] load_addr;
        logic [15:0] chip_len;
        logic [13:0] remaining;
        logic [12:0] hi_ofs;
        logic [5:0]  top_bank;
        logic [1:0]  err;

        res_t        due_results[$];
        int          mismatches = 0;
        int          results_seen = 0;
        int          writes_seen = 0;
        int          bytes_in = 0;
        int          images_ended = 0;

        function new();
            raw_order = 1'b0;
            clear_parse();
        endfunction

        function void clear_parse();
            state     = PH_IMAGE_HDR;
            pos       = '0;
            type_code = '0;
            mode      = MODE_NONE;
            rom       = '0;
            bank      = '0;
            load_addr = '0;
            chip_len  = '0;
            remaining = '0;
            hi_ofs    = '0;
            top_bank  = '0;
            err       = ST_OK;
        endfunction

        // first error wins
        function void flag(logic [1:0] code);
            if (err == ST_OK)
                err = code;
        endfunction

        function void decode_type(logic [7:0] rsv0);
            rom = 2'd1;
            case (type_code)
                16'd32:  begin mode = MODE_T32; rom = 2'd3; end
                16'd19:  mode = MODE_T19;
                16'd7:   mode = MODE_T7;
                16'd43:  mode = MODE_T43;
                16'd57:  mode = (rsv0 == 8'd0) ? MODE_T57R : MODE_T57H;
                16'd3:   begin mode = MODE_T3; rom = 2'd3; end
                16'd1:   mode = MODE_T1;
                16'd9:   mode = MODE_T9;
                16'd15:  mode = MODE_T15;
                16'd60:  mode = MODE_T60;
                16'd18:  mode = MODE_T18;
                16'd5:   mode = MODE_T5;
                16'd21:  begin mode = MODE_T21; rom = 2'd3; end
                16'd10:  mode = MODE_T10;
                16'd4:   mode = MODE_T4;
                16'd17:  mode = MODE_T17;
                default: begin mode = MODE_NONE; rom = 2'd0; end
            endcase
        endfunction

        function bit low_only_layout();
            return mode == MODE_T19 || mode == MODE_T15 || mode == MODE_T7 ||
                   mode == MODE_T43 || mode == MODE_T5 || mode == MODE_T60 ||
                   mode == MODE_T57H || mode == MODE_T57R || type_code == TYPE_LOW_ONLY;
        endfunction

        function bit in_data();
            return state == PH_LOW_ONLY || state == PH_LOW_IL || state == PH_HIGH_IL;
        endfunction

        function void start_data();
            int n;
            pos    = '0;
            hi_ofs = '0;
            if (bank < BANK_LIMIT && bank > top_bank)
                top_bank = bank[5:0];
            if (low_only_layout())
            begin
                rom   = 2'd1;
                n     = (chip_len < 8192) ? chip_len : 8192;
                state = PH_LOW_ONLY;
            end
            else if (load_addr == ADDR_ROML)
            begin
                rom[0] = 1'b1;
                n      = (chip_len < 8192) ? chip_len : 8192;
                state  = PH_LOW_IL;
            end
            else
            begin
                if (load_addr == ADDR_ROMH_F || load_addr == ADDR_ROMH_B)
                    hi_ofs = 13'd4096;
                rom[1] = 1'b1;
                n      = 8192 - hi_ofs;
                state  = PH_HIGH_IL;
            end
            remaining = 14'(n);
            if (n == 0)
                state = PH_CHIP_HDR;
        endfunction

        function void predict_byte(logic [7:0] b, logic lst);
            res_t        r;
            int          p;
            int unsigned idx;
            int unsigned o;
            int unsigned addr;
            r = '0;
            bytes_in++;
            case (state)
                PH_IMAGE_HDR:
                begin
                    p = int'(pos[5:0]);
                    if (p < 16 && b != IMAGE_MAGIC[8*p +: 8])
                        flag(ST_BAD_IMAGE);
                    if (p == 22 || p == 23)
                        type_code = {type_code[7:0], b};
                    if (p == 26)
                        decode_type(b);
                    if (p == 63)
                    begin
                        pos   = '0;
                        state = PH_CHIP_HDR;
                    end
                    else
                        pos = 14'(p + 1);
                end
                PH_CHIP_HDR:
                begin
                    p = int'(pos[3:0]);
                    if (p < 4 && b != CHIP_MAGIC[8*p +: 8])
                        flag(ST_BAD_CHIP);
                    if (p == 10 || p == 11)
                        bank = {bank[7:0], b};
                    if (p == 12 || p == 13)
                        load_addr = {load_addr[7:0], b};
                    if (p == 14 || p == 15)
                        chip_len = {chip_len[7:0], b};
                    if (p == 11 && bank >= BANK_LIMIT)
                        flag(ST_BAD_BANK);
                    pos = 14'(p + 1);
                    if (p == 15)
                        start_data();
                end
                default:
                begin
                    idx = (pos + hi_ofs) & 32'h1fff;
                    // swap the 8-bit and 5-bit parts of the offset
                    o = raw_order ? idx : (((idx & 255) << 5) | ((idx >> 8) & 31));
                    addr = bank * 8192 + o;
                    if (state == PH_LOW_IL)
                        addr = addr * 2;
                    else if (state == PH_HIGH_IL)
                        addr = addr * 2 + 1;
                    if (err == ST_OK && bank < BANK_LIMIT)
                    begin
                        r.write_enable  = 1'b1;
                        r.flash_address = addr[19:0];
                        r.flash_data    = b;
                    end
                    pos = pos + 14'd1;
                    if (remaining != 0)
                        remaining = remaining - 14'd1;
                    if (remaining == 0)
                    begin
                        pos = '0;
                        if (state == PH_LOW_IL && chip_len > 8192)
                        begin
                            rom[1]    = 1'b1;
                            hi_ofs    = '0;
                            remaining = 14'((chip_len - 8192 < 8192) ? chip_len - 8192 : 8192);
                            state     = PH_HIGH_IL;
                        end
                        else
                            state = PH_CHIP_HDR;
                    end
                end
            endcase
            r.cart_mode    = mode;
            r.rom_lines    = rom;
            r.bank_count   = {1'b0, top_bank} + 7'd1;
            r.status       = err;
            r.end_of_image = lst;
            due_results.push_back(r);
            if (lst)
            begin
                images_ended++;
                clear_parse();
            end
        endfunction

        function void field_check(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                // keep the log bounded on a badly broken block
                if (mismatches < 200)
                    $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void compare_output(res_t got);
            res_t want;
            if (due_results.size() == 0)
            begin
                if (mismatches < 200)
                    $display("%0t: result with none expected, expected none actual %h",
                             $time, got);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            results_seen++;
            if (got.write_enable)
                writes_seen++;
            field_check("write_enable", want.write_enable, got.write_enable);
            field_check("flash_address", want.flash_address, got.flash_address);
            field_check("flash_data", want.flash_data, got.flash_data);
            field_check("cart_mode", want.cart_mode, got.cart_mode);
            field_check("rom_lines", want.rom_lines, got.rom_lines);
            field_check("bank_count", want.bank_count, got.bank_count);
            field_check("status", want.status, got.status);
            field_check("end_of_image", want.end_of_image, got.end_of_image);
        endfunction

    endclass

endpackage

FILE: dv/tb_top.sv
module tb_top;

    import cifl_pkg::*;
    import loader_check_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] file_byte
    logic        s_axis_tlast = 1'b0;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [0] write_enable, [20:1] flash_address, [28:21] flash_data,
    // [33:29] cart_mode, [35:34] rom_lines, [42:36] bank_count, [44:43] status
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;          // end_of_image
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_data = 1'b0;       // raw_order

    flash_write_tracker tracker;
    res_t               seen;

    // when set, neither side inserts gaps or stalls
    bit quiet = 1'b1;

    // per-image bookkeeping: bytes sent so far, truncation point, image closed
    int img_sent;
    int img_cut;
    bit img_done;
    int cfg_writes = 0;

    // type values to pick from; 0, 2, 36 and 16'hffff map to no mode
    int unsigned type_pool [20] = '{0, 1, 3, 4, 5, 7, 9, 10, 15, 17, 18, 19, 21,
                                    32, 36, 43, 57, 60, 2, 16'hffff};

    cartridge_image_flash_loader #(
        .MAX_BANKS(BANK_LIMIT)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // result side back-pressure, changes only at the falling edge
    initial
    begin : rx_stall
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold == 0)
                hold = pick_gap();
            if (hold == 0)
                m_axis_tready <= 1'b1;
            else
            begin
                m_axis_tready <= 1'b0;
                hold--;
            end
        end
    end

    // every result transaction is unpacked and checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.write_enable  = m_axis_tdata[0];
            seen.flash_address = m_axis_tdata[20:1];
            seen.flash_data    = m_axis_tdata[28:21];
            seen.cart_mode     = m_axis_tdata[33:29];
            seen.rom_lines     = m_axis_tdata[35:34];
            seen.bank_count    = m_axis_tdata[42:36];
            seen.status        = m_axis_tdata[44:43];
            seen.end_of_image  = m_axis_tlast;
            tracker.compare_output(seen);
        end
    end

    // one image byte as one input transaction, optional gap in front of it
    task automatic push_byte(input logic [7:0] b, input logic lst);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= lst;
        do @(posedge clk); while (!s_axis_tready);
        tracker.predict_byte(b, lst);
    endtask

    // next byte of the current image; ends it if the truncation point is hit
    task automatic put(input logic [7:0] b);
        if (!img_done)
        begin
            img_sent++;
            img_done = (img_sent == img_cut);
            push_byte(b, img_done);
        end
    endtask

    task automatic put_last(input logic [7:0] b);
        if (!img_done)
        begin
            img_sent++;
            img_done = 1'b1;
            push_byte(b, 1'b1);
        end
    endtask

    // 64-byte image header; cut 0 means no truncation, bad_pos < 0 keeps the signature
    task automatic send_header(input logic [15:0] ty, input logic [7:0] rsv0,
                               input int cut, input int bad_pos);
        logic [7:0] b;
        logic [7:0] flip;
        img_sent = 0;
        img_cut  = cut;
        img_done = 1'b0;
        for (int i = 0; i < 64; i++)
        begin
            b    = 8'($urandom_range(0, 255));
            flip = 8'($urandom_range(1, 255));
            if (i < 16)
                b = IMAGE_MAGIC[8*i +: 8];
            if (i == bad_pos)
                b = b ^ flip;
            if (i == 22)
                b = ty[15:8];
            if (i == 23)
                b = ty[7:0];
            if (i == 26)
                b = rsv0;
            put(b);
        end
    endtask

    // chip packet: 16-byte header, then data for as long as the block expects it;
    // cap > 0 ends the image on that data byte if the chip runs that long
    task automatic send_chip(input logic [15:0] bank, input logic [15:0] load,
                             input logic [15:0] len, input int bad_pos, input int cap);
        logic [7:0] b;
        logic [7:0] flip;
        int         n;
        for (int i = 0; i < 16; i++)
        begin
            b    = 8'($urandom_range(0, 255));
            flip = 8'($urandom_range(1, 255));
            if (i < 4)
                b = CHIP_MAGIC[8*i +: 8];
            if (i == bad_pos)
                b = b ^ flip;
            case (i)
                10: b = bank[15:8];
                11: b = bank[7:0];
                12: b = load[15:8];
                13: b = load[7:0];
                14: b = len[15:8];
                15: b = len[7:0];
                default: ;
            endcase
            put(b);
        end
        n = 0;
        while (!img_done && tracker.in_data())
        begin
            if (cap != 0 && n == cap - 1)
                put_last(8'($urandom_range(0, 255)));
            else
                put(8'($urandom_range(0, 255)));
            n++;
        end
    endtask

    // close the image with a partial or complete chip header, its last byte carrying tlast
    task automatic finish_image();
        int k;
        k = $urandom_range(1, 16);
        for (int j = 0; j < k; j++)
        begin
            if (j == k - 1)
                put_last((j < 4) ? CHIP_MAGIC[8*j +: 8] : 8'($urandom_range(0, 255)));
            else
                put((j < 4) ? CHIP_MAGIC[8*j +: 8] : 8'($urandom_range(0, 255)));
        end
    endtask

    // stop sending and wait until every predicted result has come back
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // raw_order is only changed while nothing is in flight
    task automatic write_raw_order(input logic v);
        settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        tracker.raw_order = v;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] ty;
        logic [7:0]  rsv;
        logic [15:0] bank;
        logic [15:0] load;
        logic [15:0] len;
        int          n_chips;
        int          stop_at;
        tracker = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_raw_order(1'b1);

        // single-byte images 0x00, 0xff and 0x43, then a bare signature ending on its last byte
        push_byte(8'h00, 1'b1);
        push_byte(8'hff, 1'b1);
        push_byte(8'h43, 1'b1);
        for (int i = 0; i < 16; i++)
            push_byte(IMAGE_MAGIC[8*i +: 8], i == 15);

        write_raw_order(1'b0);

        // a sample of type values, header cut on the byte where the mode is decoded
        repeat (6)
        begin
            quiet = ($urandom_range(0, 2) == 0);
            ty = 16'(type_pool[$urandom_range(0, 19)]);
            send_header(ty, (ty == 16'd57) ? 8'd0 : 8'($urandom_range(0, 255)), 27, -1);
        end
        send_header(16'd57, 8'($urandom_range(1, 255)), 27, -1);

        write_raw_order(1'b1);

        // random images: mostly well-formed, with broken signatures, bad banks,
        // empty chips and truncation in the header or early in the chip data mixed in
        stop_at = tracker.bytes_in + 200;
        while (tracker.bytes_in < stop_at)
        begin
            if ($urandom_range(0, 3) == 0)
                write_raw_order(1'($urandom_range(0, 1)));
            quiet = ($urandom_range(0, 4) == 0);
            ty = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'(type_pool[$urandom_range(0, 19)]);
            rsv = (ty == 16'd57 && $urandom_range(0, 1) == 1) ? 8'd0
                                                              : 8'($urandom_range(0, 255));
            send_header(ty, rsv, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : 0,
                        ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : -1);
            n_chips = $urandom_range(0, 3);
            repeat (n_chips)
            begin
                case ($urandom_range(0, 19))
                    0:       bank = 16'd63;
                    1:       bank = 16'(BANK_LIMIT);
                    2:       bank = 16'($urandom_range(65, 65534));
                    3:       bank = 16'hffff;
                    default: bank = 16'($urandom_range(0, 62));
                endcase
                case ($urandom_range(0, 7))
                    3:       load = ADDR_ROMH_F;
                    4:       load = ADDR_ROMH_B;
                    5:       load = 16'ha000;
                    6:       load = 16'he000;
                    7:       load = 16'($urandom_range(0, 65535));
                    default: load = ADDR_ROML;
                endcase
                case ($urandom_range(0, 9))
                    0, 1:    len = 16'd0;
                    2:       len = 16'($urandom_range(0, 65535));
                    default: len = 16'($urandom_range(1, 14));
                endcase
                send_chip(bank, load, len,
                          ($urandom_range(0, 11) == 0) ? $urandom_range(0, 3) : -1,
                          $urandom_range(1, 20));
            end
            finish_image();
        end

        settle();
        repeat (16) @(posedge clk);

        $display("covered %0d image bytes in %0d images, %0d results, %0d flash writes",
                 tracker.bytes_in, tracker.images_ended, tracker.results_seen,
                 tracker.writes_seen);
        $display("raw_order written %0d times, %0d mismatches",
                 cfg_writes, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.due_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // hard stop in case a handshake never completes
    initial
    begin
        #20000000;
        $display("timeout, %0d results still outstanding", tracker.due_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
